[hdl/cartridge_bank_mapper_rtc_defines.svh]
// assertion macros shared by the mapper rtl
// no dependencies; included by the files that carry checks
`ifndef CARTRIDGE_BANK_MAPPER_RTC_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_RTC_DEFINES_SVH

// condition must hold at every edge out of reset
`define CBMR_ASSERT_ALWAYS(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("cbmr check failed");

// consequent must hold in the same cycle as the antecedent
`define CBMR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbmr check failed");

// consequent must hold in the cycle after the antecedent
`define CBMR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbmr check failed");

`endif

[hdl/cbmr_pkg.sv]
// types and codes for the cartridge bank mapper with clock
// no dependencies; used by every module of the block
`default_nettype none

package cbmr_pkg;

  // bus actions
  localparam logic [2:0] ACT_ROM_RD  = 3'd0;
  localparam logic [2:0] ACT_CTRL_WR = 3'd1;
  localparam logic [2:0] ACT_RAM_RD  = 3'd2;
  localparam logic [2:0] ACT_RAM_WR  = 3'd3;
  localparam logic [2:0] ACT_TICK    = 3'd4;

  // result targets
  localparam logic [1:0] TGT_NONE   = 2'd0;
  localparam logic [1:0] TGT_ROM_RD = 2'd1;
  localparam logic [1:0] TGT_RAM_RD = 2'd2;
  localparam logic [1:0] TGT_RAM_WR = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_ROM_BANK_COUNT = 3'd0;
  localparam logic [2:0] CFG_ROM_BYTES      = 3'd1;
  localparam logic [2:0] CFG_RAM_BANK_COUNT = 3'd2;
  localparam logic [2:0] CFG_RAM_BYTES      = 3'd3;
  localparam logic [2:0] CFG_RAM_PRESENT    = 3'd4;
  localparam logic [2:0] CFG_RTC_PRESENT    = 3'd5;
  localparam logic [2:0] CFG_WIDE_ROM_BANK  = 3'd6;

  localparam int unsigned CfgDataW = 23;

  // control write regions, address bits 14:13
  localparam logic [1:0] REG_RAM_EN   = 2'd0;
  localparam logic [1:0] REG_ROM_BANK = 2'd1;
  localparam logic [1:0] REG_RAM_BANK = 2'd2;

  // clock register selects
  localparam logic [7:0] RTC_SEC    = 8'h08;
  localparam logic [7:0] RTC_MIN    = 8'h09;
  localparam logic [7:0] RTC_HOUR   = 8'h0A;
  localparam logic [7:0] RTC_DAY_LO = 8'h0B;
  localparam logic [7:0] RTC_DAY_HI = 8'h0C;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;
  localparam logic [7:0] OPEN_BUS   = 8'hFF;
  localparam logic [7:0] LATCH_IDLE = 8'hFF;
  localparam logic [7:0] LATCH_ARM  = 8'h00;
  localparam logic [7:0] LATCH_FIRE = 8'h01;

  typedef struct packed {
    logic [8:0]  rom_bank_count;
    logic [22:0] rom_bytes;
    logic [3:0]  ram_bank_count;
    logic [16:0] ram_bytes;
    logic        ram_present;
    logic        rtc_present;
    logic        wide_rom_bank;
  } cfg_t;

  typedef struct packed {
    logic [8:0] days;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       halt;
    logic       carry;
  } rtc_time_t;

  typedef struct packed {
    logic       tick;
    logic       latch;
    logic       wr;
    logic [7:0] sel;
    logic [7:0] data;
  } rtc_cmd_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [21:0] mem_offset;
    logic [7:0]  read_data;
    logic [7:0]  ram_write_data;
    logic        dirty;
  } result_t;

endpackage

`default_nettype wire

[hdl/cbmr_cfg.sv]
// cartridge description registers, written through a plain write port
// depends on cbmr_pkg
`default_nettype none

module cbmr_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [2:0]                   cfg_addr_i,
  input  wire logic [cbmr_pkg::CfgDataW-1:0] cfg_data_i,
  output cbmr_pkg::cfg_t                    cfg_o
);

  cbmr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        cbmr_pkg::CFG_ROM_BANK_COUNT: cfg_d.rom_bank_count = cfg_data_i[8:0];
        cbmr_pkg::CFG_ROM_BYTES:      cfg_d.rom_bytes      = cfg_data_i[22:0];
        cbmr_pkg::CFG_RAM_BANK_COUNT: cfg_d.ram_bank_count = cfg_data_i[3:0];
        cbmr_pkg::CFG_RAM_BYTES:      cfg_d.ram_bytes      = cfg_data_i[16:0];
        cbmr_pkg::CFG_RAM_PRESENT:    cfg_d.ram_present    = cfg_data_i[0];
        cbmr_pkg::CFG_RTC_PRESENT:    cfg_d.rtc_present    = cfg_data_i[0];
        cbmr_pkg::CFG_WIDE_ROM_BANK:  cfg_d.wide_rom_bank  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/cbmr_rtc.sv]
// real-time clock counters, register writes, tick carry chain and latch copy
// depends on cbmr_pkg and the assertion macro header
`default_nettype none
`include "cartridge_bank_mapper_rtc_defines.svh"

module cbmr_rtc (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cbmr_pkg::rtc_cmd_t cmd_i,
  output cbmr_pkg::rtc_time_t     held_o
);

  cbmr_pkg::rtc_time_t run_q, run_d, held_q, held_d;

  logic [6:0] sec_inc;
  logic       sec_wrap;
  logic [6:0] min_inc;
  logic       min_wrap;
  logic [5:0] hour_inc;
  logic       hour_wrap;
  logic [9:0] day_inc;

  // mixed radix carry chain, each digit wraps at most once per tick
  always_comb begin
    sec_inc   = {1'b0, run_q.seconds} + 7'd1;
    sec_wrap  = (sec_inc >= 7'd60);
    min_inc   = {1'b0, run_q.minutes} + {6'd0, sec_wrap};
    min_wrap  = (min_inc >= 7'd60);
    hour_inc  = {1'b0, run_q.hours} + {5'd0, min_wrap};
    hour_wrap = (hour_inc >= 6'd24);
    day_inc   = {1'b0, run_q.days} + {9'd0, hour_wrap};
  end

  always_comb begin
    run_d  = run_q;
    held_d = held_q;
    if (cmd_i.tick && !run_q.halt) begin
      run_d.seconds = sec_wrap  ? 6'(sec_inc - 7'd60)  : sec_inc[5:0];
      run_d.minutes = min_wrap  ? 6'(min_inc - 7'd60)  : min_inc[5:0];
      run_d.hours   = hour_wrap ? 5'(hour_inc - 6'd24) : hour_inc[4:0];
      run_d.days    = day_inc[8:0];
      run_d.carry   = run_q.carry | day_inc[9];
    end
    if (cmd_i.wr) begin
      case (cmd_i.sel)
        cbmr_pkg::RTC_SEC:    run_d.seconds = cmd_i.data[5:0];
        cbmr_pkg::RTC_MIN:    run_d.minutes = cmd_i.data[5:0];
        cbmr_pkg::RTC_HOUR:   run_d.hours   = cmd_i.data[4:0];
        cbmr_pkg::RTC_DAY_LO: run_d.days    = {run_q.days[8], cmd_i.data};
        cbmr_pkg::RTC_DAY_HI: begin
          run_d.days  = {cmd_i.data[0], run_q.days[7:0]};
          run_d.halt  = cmd_i.data[6];
          run_d.carry = cmd_i.data[7];
        end
        default: ;
      endcase
    end
    if (cmd_i.latch) begin
      held_d = run_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      held_q <= '0;
    end else begin
      run_q  <= run_d;
      held_q <= held_d;
    end
  end

  assign held_o = held_q;

  `CBMR_ASSERT_NEXT(a_halt_freezes, clk_i, rst_ni, cmd_i.tick && run_q.halt, $stable(run_q))
  `CBMR_ASSERT_NEXT(a_carry_sticky, clk_i, rst_ni, cmd_i.tick && run_q.carry, run_q.carry)

endmodule

`default_nettype wire

[hdl/cbmr_map.sv]
// bank select registers and per-word address decode into a result
// depends on cbmr_pkg and the assertion macro header
`default_nettype none
`include "cartridge_bank_mapper_rtc_defines.svh"

module cbmr_map (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire logic [2:0]          action_i,
  input  wire logic [15:0]         address_i,
  input  wire logic [7:0]          write_data_i,
  input  wire cbmr_pkg::cfg_t      cfg_i,
  input  wire cbmr_pkg::rtc_time_t held_i,
  output cbmr_pkg::rtc_cmd_t       rtc_cmd_o,
  output cbmr_pkg::result_t        res_o
);

  logic       ram_en_q, ram_en_d;
  logic [7:0] rom_bank_q, rom_bank_d;
  logic [7:0] ram_bank_q, ram_bank_d;
  logic [7:0] latch_q, latch_d;

  logic [8:0]  rom_mask;
  logic [7:0]  rom_bank_m;
  logic [21:0] rom_off;
  logic        rom_hit;
  logic [3:0]  ram_mask;
  logic [2:0]  ram_bank_m;
  logic [15:0] ram_off;
  logic        ram_hit;
  logic        in_ram_area;
  logic        ram_sel;
  logic [7:0]  rtc_rd;
  logic [7:0]  rom_bank_wr;
  cbmr_pkg::rtc_cmd_t cmd;

  always_comb begin
    rom_mask    = cfg_i.rom_bank_count - 9'd1;
    rom_bank_m  = (cfg_i.rom_bank_count == 9'd0) ? rom_bank_q : (rom_bank_q & rom_mask[7:0]);
    rom_off     = address_i[14] ? {rom_bank_m, address_i[13:0]} : {8'd0, address_i[13:0]};
    rom_hit     = ({1'b0, rom_off} < cfg_i.rom_bytes);
    ram_mask    = cfg_i.ram_bank_count - 4'd1;
    ram_bank_m  = (cfg_i.ram_bank_count == 4'd0) ? ram_bank_q[2:0]
                                                 : (ram_bank_q[2:0] & ram_mask[2:0]);
    ram_off     = {ram_bank_m, address_i[12:0]};
    ram_hit     = ({1'b0, ram_off} < cfg_i.ram_bytes);
    in_ram_area = (address_i[15:13] == 3'b101);
    ram_sel     = (ram_bank_q[7:3] == 5'd0);
    rom_bank_wr = cfg_i.wide_rom_bank ? write_data_i : {1'b0, write_data_i[6:0]};
  end

  always_comb begin
    case (ram_bank_q)
      cbmr_pkg::RTC_SEC:    rtc_rd = {2'd0, held_i.seconds};
      cbmr_pkg::RTC_MIN:    rtc_rd = {2'd0, held_i.minutes};
      cbmr_pkg::RTC_HOUR:   rtc_rd = {3'd0, held_i.hours};
      cbmr_pkg::RTC_DAY_LO: rtc_rd = held_i.days[7:0];
      cbmr_pkg::RTC_DAY_HI: rtc_rd = {held_i.carry, held_i.halt, 5'd0, held_i.days[8]};
      default:              rtc_rd = cbmr_pkg::OPEN_BUS;
    endcase
  end

  always_comb begin
    res_o      = '0;
    cmd        = '0;
    cmd.sel    = ram_bank_q;
    cmd.data   = write_data_i;
    ram_en_d   = ram_en_q;
    rom_bank_d = rom_bank_q;
    ram_bank_d = ram_bank_q;
    latch_d    = latch_q;
    case (action_i)
      cbmr_pkg::ACT_ROM_RD: begin
        res_o.read_data = cbmr_pkg::OPEN_BUS;
        if (!address_i[15] && rom_hit) begin
          res_o.target     = cbmr_pkg::TGT_ROM_RD;
          res_o.mem_offset = rom_off;
          res_o.read_data  = '0;
        end
      end
      cbmr_pkg::ACT_CTRL_WR: begin
        if (!address_i[15]) begin
          case (address_i[14:13])
            cbmr_pkg::REG_RAM_EN:   ram_en_d = (write_data_i[3:0] == cbmr_pkg::RAM_EN_KEY);
            cbmr_pkg::REG_ROM_BANK: rom_bank_d = (rom_bank_wr == 8'd0) ? 8'd1 : rom_bank_wr;
            cbmr_pkg::REG_RAM_BANK: ram_bank_d = write_data_i;
            default: begin
              // latch region: a zero then one sequence copies the clock
              cmd.latch = cfg_i.rtc_present && (latch_q == cbmr_pkg::LATCH_ARM)
                          && (write_data_i == cbmr_pkg::LATCH_FIRE);
              latch_d   = write_data_i;
              res_o.dirty = 1'b1;
            end
          endcase
        end
      end
      cbmr_pkg::ACT_RAM_RD: begin
        res_o.read_data = cbmr_pkg::OPEN_BUS;
        if (in_ram_area && ram_en_q) begin
          if (ram_sel) begin
            if (cfg_i.ram_present && ram_hit) begin
              res_o.target     = cbmr_pkg::TGT_RAM_RD;
              res_o.mem_offset = {6'd0, ram_off};
              res_o.read_data  = '0;
            end
          end else if (cfg_i.rtc_present) begin
            res_o.read_data = rtc_rd;
          end
        end
      end
      cbmr_pkg::ACT_RAM_WR: begin
        if (in_ram_area && ram_en_q) begin
          if (ram_sel) begin
            if (cfg_i.ram_present) begin
              res_o.dirty = 1'b1;
              if (ram_hit) begin
                res_o.target         = cbmr_pkg::TGT_RAM_WR;
                res_o.mem_offset     = {6'd0, ram_off};
                res_o.ram_write_data = write_data_i;
              end
            end
          end else if (cfg_i.rtc_present) begin
            cmd.wr = 1'b1;
            res_o.dirty = 1'b1;
          end
        end
      end
      cbmr_pkg::ACT_TICK: cmd.tick = 1'b1;
      default: ;
    endcase
  end

  // commands and bank updates take effect only when the word moves on
  assign rtc_cmd_o = fire_i ? cmd : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_en_q   <= 1'b0;
      rom_bank_q <= 8'd1;
      ram_bank_q <= 8'd0;
      latch_q    <= cbmr_pkg::LATCH_IDLE;
    end else if (fire_i) begin
      ram_en_q   <= ram_en_d;
      rom_bank_q <= rom_bank_d;
      ram_bank_q <= ram_bank_d;
      latch_q    <= latch_d;
    end
  end

  `CBMR_ASSERT_ALWAYS(a_rom_bank_nonzero, clk_i, rst_ni, rom_bank_q != 8'd0)

endmodule

`default_nettype wire

[hdl/cartridge_bank_mapper_rtc.sv]
// a word is accepted into the input stage, decoded from there, and its result is registered in the result stage
// throughput: one word per cycle while results are taken, set by the single input stage feeding the result stage
// the input stage can still take a new word while the previous result waits to be taken
// reset: asynchronous, active low; empties both stages, clears configuration to zero,
// clock and latched clock to zero, rom bank to one, ram bank and enable to zero
`default_nettype none
`include "cartridge_bank_mapper_rtc_defines.svh"

module cartridge_bank_mapper_rtc (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [2:0]                   cfg_addr_i,
  input  wire logic [cbmr_pkg::CfgDataW-1:0] cfg_data_i,
  // bus action input
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [2:0]                   action_i,
  input  wire logic [15:0]                  address_i,
  input  wire logic [7:0]                   write_data_i,
  // result output
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [1:0]                   target_o,
  output      logic [21:0]                  mem_offset_o,
  output      logic [7:0]                   read_data_o,
  output      logic [7:0]                   ram_write_data_o,
  output      logic                         dirty_o
);

  cbmr_pkg::cfg_t      cfg;
  cbmr_pkg::rtc_time_t held;
  cbmr_pkg::rtc_cmd_t  rtc_cmd;
  cbmr_pkg::result_t   res;
  cbmr_pkg::result_t   res_q;

  // input stage
  logic        in_vld_q, in_vld_d;
  logic [2:0]  action_q;
  logic [15:0] address_q;
  logic [7:0]  wdata_q;

  logic out_vld_q, out_vld_d;
  logic adv;
  logic fire;
  logic in_fire;

  // input stage moves on when the result stage is empty or being drained
  assign adv        = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && adv;
  assign in_ready_o = !in_vld_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q  <= action_i;
      address_q <= address_i;
      wdata_q   <= write_data_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  cbmr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // decode and bank state; state updates land as the word leaves the input stage
  cbmr_map u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .action_i     (action_q),
    .address_i    (address_q),
    .write_data_i (wdata_q),
    .cfg_i        (cfg),
    .held_i       (held),
    .rtc_cmd_o    (rtc_cmd),
    .res_o        (res)
  );

  cbmr_rtc u_rtc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (rtc_cmd),
    .held_o (held)
  );

  assign out_valid_o      = out_vld_q;
  assign target_o         = res_q.target;
  assign mem_offset_o     = res_q.mem_offset;
  assign read_data_o      = res_q.read_data;
  assign ram_write_data_o = res_q.ram_write_data;
  assign dirty_o          = res_q.dirty;

  // a mapped access never carries read data of its own
  `CBMR_ASSERT_IMP(a_access_no_rdata, clk_i, rst_ni, out_vld_q && (res_q.target != cbmr_pkg::TGT_NONE), res_q.read_data == 8'd0)
  // store data only travels with a ram write
  `CBMR_ASSERT_IMP(a_wdata_only_on_write, clk_i, rst_ni, out_vld_q && (res_q.target != cbmr_pkg::TGT_RAM_WR), res_q.ram_write_data == 8'd0)

endmodule

`default_nettype wire
